>>> rtl/fcte_pkg.sv
`default_nettype none

package fcte_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 4096;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

    // Field widths
    localparam int CL_W   = 16;
    localparam int CNT_W  = 13;
    localparam int MODE_W = 2;
    localparam int ST_W   = 2;
    // Wide enough to hold TABLE_ENTRIES itself for compares
    localparam int CMP_W  = CL_W + 1;

    localparam logic [CNT_W-1:0]  LIMIT_RESET   = CNT_W'(4096);
    localparam logic [CNT_W-1:0]  MAX_CHAIN     = CNT_W'(4096);
    localparam logic [CL_W-1:0]   ENTRY_FREE    = 16'h0000;
    localparam logic [CL_W-1:0]   ENTRY_EOC     = 16'hFFFF;
    localparam logic [CL_W-1:0]   CHAIN_END_MIN = 16'hFFF8;
    localparam logic [CL_W-1:0]   FIRST_CLUSTER = 16'd2;
    localparam logic [CMP_W-1:0]  TABLE_SIZE    = CMP_W'(TABLE_ENTRIES);

    typedef enum logic [MODE_W-1:0] {
        MODE_READ,
        MODE_WRITE,
        MODE_ALLOC,
        MODE_FREE
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        STAT_OK,
        STAT_FULL,
        STAT_RANGE,
        STAT_LONG
    } t_status;

    // Source of the result entry value
    typedef enum logic [1:0] {
        EV_ZERO,
        EV_RDATA,
        EV_FOUND
    } t_ev_sel;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_SCAN,
        ST_MARK,
        ST_LINK,
        ST_WALK,
        ST_WALK_RD,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        logic    clr_wr;
        logic    rd_cluster;
        logic    wr_entry;
        logic    scan_step;
        logic    mark_eoc;
        logic    link_wr;
        logic    walk_rd;
        logic    walk_clr;
        logic    res_set;
        t_ev_sel res_ev;
        t_status res_st;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  clr_last;
        logic  idx_out;
        logic  link_bad;
        logic  link_nz;
        logic  scan_hit;
        logic  scan_done;
        logic  walk_end;
        logic  walk_long;
        logic  walk_out;
        logic  out_free;
    } t_dp_stat;

    function automatic logic in_table(input logic [CL_W-1:0] idx);
        return CMP_W'(idx) < TABLE_SIZE;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fcte_dp.sv
`default_nettype none

module fcte_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  fcte_pkg::t_dp_cmd            i_cmd,
    output fcte_pkg::t_dp_stat           o_stat,
    // request fields
    input  fcte_pkg::t_mode              i_mode,
    input  wire [fcte_pkg::CL_W-1:0]     i_cluster,
    input  wire [fcte_pkg::CL_W-1:0]     i_value,
    input  wire [fcte_pkg::CL_W-1:0]     i_link,
    // config
    input  wire                          i_cfg_we,
    input  wire [fcte_pkg::CNT_W-1:0]    i_cfg_data,
    // result side
    input  wire                          i_out_ready,
    output logic                         o_out_valid,
    output logic [fcte_pkg::CL_W-1:0]    o_out_ev,
    output fcte_pkg::t_status            o_out_st,
    output logic [fcte_pkg::CNT_W-1:0]   o_out_cnt
);

    localparam int AW = fcte_pkg::TBL_AW;
    localparam int DW = fcte_pkg::CL_W;

    logic [DW-1:0]    r_mem [fcte_pkg::TABLE_ENTRIES];
    logic [DW-1:0]    r_rd_data;

    fcte_pkg::t_mode  r_mode;
    logic [DW-1:0]    r_cluster;
    logic [DW-1:0]    r_value;
    logic [DW-1:0]    r_link;
    logic [fcte_pkg::CNT_W-1:0] r_limit;
    logic [DW-1:0]    r_ptr;
    logic [fcte_pkg::CNT_W-1:0] r_count;
    logic             r_pend;
    logic [AW-1:0]    r_pend_addr;
    logic [AW-1:0]    r_clr_addr;
    logic [DW-1:0]    r_res_ev;
    fcte_pkg::t_status r_res_st;

    logic             r_out_valid;
    logic [DW-1:0]    r_out_ev;
    fcte_pkg::t_status r_out_st;
    logic [fcte_pkg::CNT_W-1:0] r_out_cnt;

    logic [fcte_pkg::CMP_W-1:0] lim_eff;
    logic             scan_more;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [DW-1:0]    wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [DW-1:0]    res_ev;

    // Scan bound: the smaller of the limit register and the table size
    always_comb begin
        if (fcte_pkg::CMP_W'(r_limit) > fcte_pkg::TABLE_SIZE) begin
            lim_eff = fcte_pkg::TABLE_SIZE;
        end else begin
            lim_eff = fcte_pkg::CMP_W'(r_limit);
        end
    end

    assign scan_more = fcte_pkg::CMP_W'(r_ptr) < lim_eff;

    // Write port select
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_clr_addr;
        wr_data = fcte_pkg::ENTRY_FREE;
        if (i_cmd.wr_entry) begin
            wr_addr = r_cluster[AW-1:0];
            wr_data = r_value;
        end else if (i_cmd.mark_eoc) begin
            wr_addr = r_pend_addr;
            wr_data = fcte_pkg::ENTRY_EOC;
        end else if (i_cmd.link_wr) begin
            wr_addr = r_link[AW-1:0];
            wr_data = DW'(r_pend_addr);
        end else if (i_cmd.walk_clr) begin
            wr_addr = r_ptr[AW-1:0];
            wr_data = fcte_pkg::ENTRY_FREE;
        end else if (!i_cmd.clr_wr) begin
            wr_en   = 1'b0;
        end
    end

    // Read port select
    always_comb begin
        rd_en   = i_cmd.rd_cluster | i_cmd.walk_rd | (i_cmd.scan_step & scan_more);
        rd_addr = i_cmd.rd_cluster ? r_cluster[AW-1:0] : r_ptr[AW-1:0];
    end

    // Table memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= fcte_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_mode;
            r_cluster <= i_cluster;
            r_value   <= i_value;
            r_link    <= i_link;
        end
    end

    // Scan pending-read tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.capture) begin
            r_pend <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_pend <= scan_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_pend_addr <= r_ptr[AW-1:0];
        end
    end

    // Scan / walk pointer and freed count
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ptr   <= (i_mode == fcte_pkg::MODE_FREE) ? i_cluster : fcte_pkg::FIRST_CLUSTER;
            r_count <= '0;
        end else if (i_cmd.scan_step && scan_more) begin
            r_ptr   <= r_ptr + DW'(1);
        end else if (i_cmd.walk_clr) begin
            r_ptr   <= r_rd_data;
            r_count <= r_count + fcte_pkg::CNT_W'(1);
        end
    end

    // Result hold
    always_comb begin
        case (i_cmd.res_ev)
            fcte_pkg::EV_RDATA: res_ev = r_rd_data;
            fcte_pkg::EV_FOUND: res_ev = DW'(r_pend_addr);
            default:            res_ev = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_ev <= res_ev;
            r_res_st <= i_cmd.res_st;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ev  <= r_res_ev;
            r_out_st  <= r_res_st;
            r_out_cnt <= r_count;
        end
    end

    // Status to controller
    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.clr_last  = &r_clr_addr;
        o_stat.idx_out   = !fcte_pkg::in_table(r_cluster);
        o_stat.link_nz   = r_link != '0;
        o_stat.link_bad  = (r_link != '0) && !fcte_pkg::in_table(r_link);
        o_stat.scan_hit  = r_pend && (r_rd_data == fcte_pkg::ENTRY_FREE);
        o_stat.scan_done = !r_pend && !scan_more;
        o_stat.walk_end  = (r_ptr < fcte_pkg::FIRST_CLUSTER) ||
                           (r_ptr >= fcte_pkg::CHAIN_END_MIN);
        o_stat.walk_long = r_count >= fcte_pkg::MAX_CHAIN;
        o_stat.walk_out  = !fcte_pkg::in_table(r_ptr);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_ev    = r_out_ev;
    assign o_out_st    = r_out_st;
    assign o_out_cnt   = r_out_cnt;

endmodule

`default_nettype wire

>>> rtl/fcte_ctrl.sv
`default_nettype none

module fcte_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    output logic                o_req_ready,
    input  fcte_pkg::t_dp_stat  i_stat,
    output fcte_pkg::t_dp_cmd   o_cmd,
    output fcte_pkg::t_state    o_state
);

    fcte_pkg::t_state r_state;
    fcte_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcte_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fcte_pkg::ST_CLEAR: begin
                if (i_stat.clr_last) n_state = fcte_pkg::ST_IDLE;
            end
            fcte_pkg::ST_IDLE: begin
                if (i_req_valid) n_state = fcte_pkg::ST_DECODE;
            end
            fcte_pkg::ST_DECODE: begin
                case (i_stat.mode)
                    fcte_pkg::MODE_READ: begin
                        n_state = i_stat.idx_out ? fcte_pkg::ST_DONE : fcte_pkg::ST_RD_WAIT;
                    end
                    fcte_pkg::MODE_WRITE: begin
                        n_state = fcte_pkg::ST_DONE;
                    end
                    fcte_pkg::MODE_ALLOC: begin
                        n_state = i_stat.link_bad ? fcte_pkg::ST_DONE : fcte_pkg::ST_SCAN;
                    end
                    default: begin
                        n_state = fcte_pkg::ST_WALK;
                    end
                endcase
            end
            fcte_pkg::ST_RD_WAIT: begin
                n_state = fcte_pkg::ST_DONE;
            end
            fcte_pkg::ST_SCAN: begin
                if (i_stat.scan_hit) begin
                    n_state = fcte_pkg::ST_MARK;
                end else if (i_stat.scan_done) begin
                    n_state = fcte_pkg::ST_DONE;
                end
            end
            fcte_pkg::ST_MARK: begin
                n_state = i_stat.link_nz ? fcte_pkg::ST_LINK : fcte_pkg::ST_DONE;
            end
            fcte_pkg::ST_LINK: begin
                n_state = fcte_pkg::ST_DONE;
            end
            fcte_pkg::ST_WALK: begin
                if (i_stat.walk_end || i_stat.walk_long || i_stat.walk_out) begin
                    n_state = fcte_pkg::ST_DONE;
                end else begin
                    n_state = fcte_pkg::ST_WALK_RD;
                end
            end
            fcte_pkg::ST_WALK_RD: begin
                n_state = fcte_pkg::ST_WALK;
            end
            fcte_pkg::ST_DONE: begin
                if (i_stat.out_free) n_state = fcte_pkg::ST_IDLE;
            end
            default: begin
                n_state = fcte_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.res_ev = fcte_pkg::EV_ZERO;
        o_cmd.res_st = fcte_pkg::STAT_OK;
        o_req_ready  = 1'b0;
        case (r_state)
            fcte_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            fcte_pkg::ST_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            fcte_pkg::ST_DECODE: begin
                case (i_stat.mode)
                    fcte_pkg::MODE_READ: begin
                        if (i_stat.idx_out) begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_st  = fcte_pkg::STAT_RANGE;
                        end else begin
                            o_cmd.rd_cluster = 1'b1;
                        end
                    end
                    fcte_pkg::MODE_WRITE: begin
                        o_cmd.res_set = 1'b1;
                        if (i_stat.idx_out) begin
                            o_cmd.res_st = fcte_pkg::STAT_RANGE;
                        end else begin
                            o_cmd.wr_entry = 1'b1;
                        end
                    end
                    fcte_pkg::MODE_ALLOC: begin
                        if (i_stat.link_bad) begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_st  = fcte_pkg::STAT_RANGE;
                        end
                    end
                    default: begin
                        o_cmd.res_set = 1'b0;
                    end
                endcase
            end
            fcte_pkg::ST_RD_WAIT: begin
                o_cmd.res_set = 1'b1;
                o_cmd.res_ev  = fcte_pkg::EV_RDATA;
            end
            fcte_pkg::ST_SCAN: begin
                if (!i_stat.scan_hit) begin
                    if (i_stat.scan_done) begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_st  = fcte_pkg::STAT_FULL;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end
            end
            fcte_pkg::ST_MARK: begin
                o_cmd.mark_eoc = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_ev   = fcte_pkg::EV_FOUND;
            end
            fcte_pkg::ST_LINK: begin
                o_cmd.link_wr = 1'b1;
            end
            fcte_pkg::ST_WALK: begin
                // end of chain wins, then length, then range
                if (i_stat.walk_end) begin
                    o_cmd.res_set = 1'b1;
                end else if (i_stat.walk_long) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_st  = fcte_pkg::STAT_LONG;
                end else if (i_stat.walk_out) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_st  = fcte_pkg::STAT_RANGE;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                end
            end
            fcte_pkg::ST_WALK_RD: begin
                o_cmd.walk_clr = 1'b1;
            end
            fcte_pkg::ST_DONE: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd.capture = 1'b0;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

>>> rtl/fat_cluster_table_engine_top.sv
`default_nettype none

// Channel   Dir  Signals                         Moves
// s (req)   in   i_s_tvalid/o_s_tready/tdata/tuser  one request: mode, cluster, value, link_from
// m (rsp)   out  o_m_tvalid/i_m_tready/tdata/tuser  one response: entry_value, status, freed_count
// cfg       in   i_cfg_valid/o_cfg_ready/i_cfg_data  cluster_limit write, always taken
//
// One request at a time: the next is not taken until the response of the last is loaded.
// An allocation scans up from cluster 2 to the smaller of the limit and the table size.
// The single-port-per-direction table memory sets the pace: one entry probed per cycle
// in the allocation scan, a read then a clear per link in the chain walk.
// After reset all 4096 table entries are cleared, one entry a cycle, before the first
// request is taken. A stalled response sits in the output register while the next
// request is accepted and worked on; that request then waits in its last state.

module fat_cluster_table_engine_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [47:0] i_s_tdata,   // cluster[15:0], value[31:16], link_from[47:32]
    input  wire  [1:0]  i_s_tuser,   // mode[1:0]
    // response
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // entry_value[15:0], freed_count[28:16], zero[31:29]
    output logic [1:0]  o_m_tuser,   // status[1:0]
    // config
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [12:0] i_cfg_data   // cluster_limit
);

    fcte_pkg::t_dp_cmd  cmd;
    fcte_pkg::t_dp_stat stat;
    fcte_pkg::t_state   state;
    fcte_pkg::t_status  out_st;
    logic [fcte_pkg::CL_W-1:0]  out_ev;
    logic [fcte_pkg::CNT_W-1:0] out_cnt;
    logic               s_accept;

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid & o_s_tready;

    // Sequencer
    fcte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_state     (state)
    );

    // Table, pointers and output register
    fcte_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (fcte_pkg::t_mode'(i_s_tuser)),
        .i_cluster   (i_s_tdata[15:0]),
        .i_value     (i_s_tdata[31:16]),
        .i_link      (i_s_tdata[47:32]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_ev    (out_ev),
        .o_out_st    (out_st),
        .o_out_cnt   (out_cnt)
    );

    // Response packing
    assign o_m_tdata = {3'b000, out_cnt, out_ev};
    assign o_m_tuser = out_st;

    // At most one source drives the table write port
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_wr, cmd.wr_entry, cmd.mark_eoc, cmd.link_wr, cmd.walk_clr}))
        else $error("table write port driven by two sources");

    // A chain entry is cleared only right after its link was read
    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_clr |-> $past(cmd.walk_rd))
        else $error("chain clear without preceding read");

    // No response is loaded in the cycle after a request is taken
    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !cmd.out_load)
        else $error("response loaded too early");

    // Requests are held off while the table is being cleared
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == fcte_pkg::ST_CLEAR) |-> !o_s_tready)
        else $error("request taken during clear sweep");

endmodule

`default_nettype wire
